### src/robb_pkg.sv
// Shared constants, types and helpers for the ray versus oriented box slab test.
`default_nettype none
package robb_pkg;

  // Fixed-point format: signed, FRAC_BITS fraction bits, 48-bit words
  localparam int FRAC_BITS = 24;
  localparam int WORD_W    = 48;
  localparam int MAG_W     = WORD_W - 1;

  // Saturation bound +-(2^47 - 1) and the value 1.0
  localparam logic [MAG_W-1:0]         SAT_MAG = '1;
  localparam logic signed [WORD_W-1:0] ONE_RAW = 48'sh1 << FRAC_BITS;

  // Tiny-scale threshold (1e-6) compared against the squared row length
  localparam longint SEPS_RAW = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
  localparam longint SEPS_SQ  = SEPS_RAW * SEPS_RAW;

  // Parallel-axis threshold (1e-7), at least one raw unit
  localparam longint DEPS_CALC = ((64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam longint DEPS_RAW  = (DEPS_CALC < 1) ? 1 : DEPS_CALC;

  // Multiplier operand split point
  localparam int MUL_SPLIT = 24;

  // Pipelined divider geometry: quotient magnitude bits, numerator, denominator
  localparam int DIV_QW  = MAG_W;
  localparam int DIV_NW  = WORD_W + 2 * FRAC_BITS;
  localparam int DIV_DW  = 96;
  localparam int DIV_LAT = DIV_QW + 1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_t;

  // Clamp a 50-bit three-term sum to +-(2^47 - 1)
  function automatic logic signed [WORD_W-1:0] sat48(input logic signed [WORD_W+1:0] x);
    logic signed [WORD_W+1:0] hi;
    logic signed [WORD_W+1:0] lo;
    hi = (WORD_W+2)'({1'b0, SAT_MAG});
    lo = -hi;
    if (x > hi)      sat48 = hi[WORD_W-1:0];
    else if (x < lo) sat48 = lo[WORD_W-1:0];
    else             sat48 = x[WORD_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/robb_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating magnitude.
`default_nettype none
module robb_div
  import robb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_NW-1:0] num,
  input  wire logic [DIV_DW-1:0] den,
  output logic      [DIV_QW-1:0] quo
);

  logic [DIV_DW-1:0] rem   [0:DIV_QW];
  logic [DIV_QW-1:0] nlo   [0:DIV_QW];
  logic [DIV_DW-1:0] den_q [0:DIV_QW];
  logic [DIV_QW-1:0] q     [0:DIV_QW];
  logic              sat   [0:DIV_QW];

  // Entry stage: overflow check and top numerator bits as first remainder
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0]   <= (DIV_DW+DIV_QW)'(num) >= {den, {DIV_QW{1'b0}}};
      rem[0]   <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
      nlo[0]   <= num[DIV_QW-1:0];
      den_q[0] <= den;
      q[0]     <= '0;
    end
  end

  // One compare-subtract per stage, most significant quotient bit first
  for (genvar k = 1; k <= DIV_QW; k++) begin : g_stage
    logic [DIV_DW:0] trial;
    logic            ge;
    always_comb begin
      trial = {rem[k-1], nlo[k-1][DIV_QW-k]};
      ge    = trial >= {1'b0, den_q[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]   <= ge ? DIV_DW'(trial - {1'b0, den_q[k-1]}) : trial[DIV_DW-1:0];
        nlo[k]   <= nlo[k-1];
        den_q[k] <= den_q[k-1];
        q[k]     <= {q[k-1][DIV_QW-2:0], ge};
        sat[k]   <= sat[k-1];
      end
    end
  end

  assign quo = sat[DIV_QW] ? SAT_MAG : q[DIV_QW];

endmodule
`default_nettype wire

### src/ray_oriented_box_slab_test.sv
// Top level of the ray versus oriented box slab test pipeline.
`default_nettype none
// Tests one box per item against the ray held in the configuration registers.
// Each item is a box world matrix (three scaled-rotation rows and a translation);
// each result says hit or miss and gives the entry distance along the ray, clamped
// at 0, in unsigned Q23.24 (saturated). The pipeline accepts one item every cycle
// and returns results in order: 4 stages form the squared row scales, a 48-stage
// divider inverts the matrix, 4 stages form the box-space ray and slab terms, a
// second 48-stage divider gives the slab bounds, and 2 stages merge them into the
// output register. A stall at the output holds the whole pipeline. The user must
// write configuration only while the pipeline is empty; the block does not check.
module ray_oriented_box_slab_test
  import robb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration write port
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data,
  // input items
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // fields from bit 0: m00 m01 m02 m10 m11 m12 m20 m21 m22 tx ty tz, 48 bits each
  input  wire logic [575:0] s_axis_tdata,
  // result items
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // fields from bit 0: hit (1), entry_distance (47)
  output logic [47:0]       m_axis_tdata
);

  localparam int NE = 9;

  logic adv;

  // Ray registers
  logic signed [47:0] org [3];
  logic signed [47:0] dir [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORG_X: org[0] <= cfg_data;
        CFG_ORG_Y: org[1] <= cfg_data;
        CFG_ORG_Z: org[2] <= cfg_data;
        CFG_DIR_X: dir[0] <= cfg_data;
        CFG_DIR_Y: dir[1] <= cfg_data;
        CFG_DIR_Z: dir[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless the output register is full and stalled
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input field unpacking
  logic signed [47:0] in_f [12];
  always_comb begin
    for (int k = 0; k < 12; k++) in_f[k] = s_axis_tdata[48*k +: 48];
  end

  // Valid bits
  logic a_v, b_v, c_v, d_v, f_v, g_v, h_v, i_v, j_v, o_v;
  logic dl1_v [DIV_LAT];
  logic dl2_v [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c_v <= 1'b0; d_v <= 1'b0;
      f_v <= 1'b0; g_v <= 1'b0; h_v <= 1'b0; i_v <= 1'b0;
      j_v <= 1'b0; o_v <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        dl1_v[k] <= 1'b0;
        dl2_v[k] <= 1'b0;
      end
    end else if (adv) begin
      a_v <= s_axis_tvalid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      dl1_v[0] <= d_v;
      dl2_v[0] <= i_v;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl1_v[k] <= dl1_v[k-1];
        dl2_v[k] <= dl2_v[k-1];
      end
      f_v <= dl1_v[DIV_LAT-1];
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
      j_v <= dl2_v[DIV_LAT-1];
      o_v <= j_v;
    end
  end

  // Stage A: matrix magnitudes and signs, origin minus translation
  logic [47:0]        a_mag [NE];
  logic [NE-1:0]      a_neg;
  logic signed [48:0] a_diff [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NE; e++) begin
        a_mag[e] <= in_f[e][47] ? 48'(-in_f[e]) : 48'(in_f[e]);
        a_neg[e] <= in_f[e][47];
      end
      for (int i = 0; i < 3; i++) a_diff[i] <= 49'(org[i]) - 49'(in_f[9+i]);
    end
  end

  // Stage B: square partial products
  logic [71:0]        b_pl [NE];
  logic [71:0]        b_ph [NE];
  logic [47:0]        b_mag [NE];
  logic [NE-1:0]      b_neg;
  logic signed [48:0] b_diff [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NE; e++) begin
        b_pl[e]  <= 72'(a_mag[e]) * 72'(a_mag[e][MUL_SPLIT-1:0]);
        b_ph[e]  <= 72'(a_mag[e]) * 72'(a_mag[e][47:MUL_SPLIT]);
        b_mag[e] <= a_mag[e];
      end
      b_neg <= a_neg;
      for (int i = 0; i < 3; i++) b_diff[i] <= a_diff[i];
    end
  end

  // Stage C: full squares
  logic [95:0]        c_sq [NE];
  logic [47:0]        c_mag [NE];
  logic [NE-1:0]      c_neg;
  logic signed [48:0] c_diff [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int e = 0; e < NE; e++) begin
        c_sq[e]  <= 96'(b_pl[e]) + (96'(b_ph[e]) << MUL_SPLIT);
        c_mag[e] <= b_mag[e];
      end
      c_neg <= b_neg;
      for (int i = 0; i < 3; i++) c_diff[i] <= b_diff[i];
    end
  end

  // Stage D: squared scale per row
  logic [95:0]        d_q2 [3];
  logic [47:0]        d_mag [NE];
  logic [NE-1:0]      d_neg;
  logic signed [48:0] d_diff [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        d_q2[j]   <= c_sq[3*j] + c_sq[3*j+1] + c_sq[3*j+2];
        d_diff[j] <= c_diff[j];
      end
      for (int e = 0; e < NE; e++) d_mag[e] <= c_mag[e];
      d_neg <= c_neg;
    end
  end

  // Inverse dividers: entry j*3+i gives inv(i,j) = m(j,i) / s_j^2;
  // a tiny scale divides by 1.0 instead
  logic [DIV_NW-1:0] div1_num [NE];
  logic [DIV_DW-1:0] div1_den [NE];
  logic [DIV_QW-1:0] inv_mag  [NE];

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      div1_num[e] = DIV_NW'(d_mag[e]) << (2 * FRAC_BITS);
      div1_den[e] = (d_q2[e/3] > 96'(SEPS_SQ)) ? d_q2[e/3]
                                                 : DIV_DW'(1) << (2 * FRAC_BITS);
    end
  end

  for (genvar e = 0; e < NE; e++) begin : g_inv
    robb_div u_div (
      .clk (clk),
      .en  (adv),
      .num (div1_num[e]),
      .den (div1_den[e]),
      .quo (inv_mag[e])
    );
  end

  // Side data traveling beside the inverse dividers
  logic [NE-1:0]      dl1_neg  [DIV_LAT];
  logic [2:0][48:0]   dl1_diff [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1_neg[0] <= d_neg;
      for (int i = 0; i < 3; i++) dl1_diff[0][i] <= d_diff[i];
      for (int k = 1; k < DIV_LAT; k++) begin
        dl1_neg[k]  <= dl1_neg[k-1];
        dl1_diff[k] <= dl1_diff[k-1];
      end
    end
  end

  // Stage F: transform partial products; product k<9 is origin term (i,j)
  // at k=j*3+i, k>=9 the matching direction term
  logic [72:0]   f_pl [2*NE];
  logic [71:0]   f_ph [2*NE];
  logic [2*NE-1:0] f_neg;

  always_ff @(posedge clk) begin
    logic [48:0]        am;
    logic               an;
    logic signed [48:0] dv;
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv = dl1_diff[DIV_LAT-1][i];
          am = dv[48] ? 49'(-dv) : 49'(dv);
          an = dv[48];
          f_pl[3*j+i]  <= 73'(am) * 73'(inv_mag[3*j+i][MUL_SPLIT-1:0]);
          f_ph[3*j+i]  <= 72'(am) * 72'(inv_mag[3*j+i][DIV_QW-1:MUL_SPLIT]);
          f_neg[3*j+i] <= an ^ dl1_neg[DIV_LAT-1][3*j+i];
          am = dir[i][47] ? 49'(-dir[i]) : 49'(dir[i]);
          an = dir[i][47];
          f_pl[NE+3*j+i]  <= 73'(am) * 73'(inv_mag[3*j+i][MUL_SPLIT-1:0]);
          f_ph[NE+3*j+i]  <= 72'(am) * 72'(inv_mag[3*j+i][DIV_QW-1:MUL_SPLIT]);
          f_neg[NE+3*j+i] <= an ^ dl1_neg[DIV_LAT-1][3*j+i];
        end
      end
    end
  end

  // Stage G: full product, cut to the format, saturated and signed
  logic signed [47:0] g_prod [2*NE];

  always_ff @(posedge clk) begin
    logic [96:0]      p;
    logic [96:0]      s;
    logic [MAG_W-1:0] m;
    if (adv) begin
      for (int k = 0; k < 2*NE; k++) begin
        p = 97'(f_pl[k]) + (97'(f_ph[k]) << MUL_SPLIT);
        s = p >> FRAC_BITS;
        m = (s > 97'(SAT_MAG)) ? SAT_MAG : s[MAG_W-1:0];
        g_prod[k] <= f_neg[k] ? -48'({1'b0, m}) : 48'({1'b0, m});
      end
    end
  end

  // Stage H: box-space origin and direction
  logic signed [47:0] h_lo [3];
  logic signed [47:0] h_ld [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        h_lo[j] <= sat48(50'(g_prod[3*j]) + 50'(g_prod[3*j+1]) + 50'(g_prod[3*j+2]));
        h_ld[j] <= sat48(50'(g_prod[NE+3*j]) + 50'(g_prod[NE+3*j+1])
                         + 50'(g_prod[NE+3*j+2]));
      end
    end
  end

  // Stage I: slab numerators, divisor and parallel-axis checks
  logic [48:0]      i_enm [3];
  logic [48:0]      i_exm [3];
  logic [MAG_W-1:0] i_den [3];
  logic [2:0]       i_negen, i_negex, i_par, i_pmiss;

  always_ff @(posedge clk) begin
    logic signed [48:0] one49;
    logic signed [48:0] lo49;
    logic signed [48:0] nen;
    logic signed [48:0] nex;
    logic [MAG_W-1:0]   ldm;
    if (adv) begin
      one49 = 49'(ONE_RAW);
      for (int j = 0; j < 3; j++) begin
        lo49 = 49'(h_lo[j]);
        nen  = -one49 - lo49;
        nex  = one49 - lo49;
        ldm  = h_ld[j][47] ? MAG_W'(-h_ld[j]) : h_ld[j][MAG_W-1:0];
        i_enm[j]   <= nen[48] ? 49'(-nen) : 49'(nen);
        i_exm[j]   <= nex[48] ? 49'(-nex) : 49'(nex);
        i_negen[j] <= nen[48] ^ h_ld[j][47];
        i_negex[j] <= nex[48] ^ h_ld[j][47];
        i_den[j]   <= ldm;
        i_par[j]   <= ldm < MAG_W'(DEPS_RAW);
        i_pmiss[j] <= (h_lo[j] < -ONE_RAW) || (h_lo[j] > ONE_RAW);
      end
    end
  end

  // Slab dividers: entry and exit per axis
  logic [DIV_QW-1:0] en_mag [3];
  logic [DIV_QW-1:0] ex_mag [3];

  for (genvar j = 0; j < 3; j++) begin : g_slab
    robb_div u_div_en (
      .clk (clk),
      .en  (adv),
      .num (DIV_NW'(i_enm[j]) << FRAC_BITS),
      .den (DIV_DW'(i_den[j])),
      .quo (en_mag[j])
    );
    robb_div u_div_ex (
      .clk (clk),
      .en  (adv),
      .num (DIV_NW'(i_exm[j]) << FRAC_BITS),
      .den (DIV_DW'(i_den[j])),
      .quo (ex_mag[j])
    );
  end

  // Side data traveling beside the slab dividers
  logic [2:0] dl2_negen [DIV_LAT];
  logic [2:0] dl2_negex [DIV_LAT];
  logic [2:0] dl2_par   [DIV_LAT];
  logic [2:0] dl2_pmiss [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2_negen[0] <= i_negen;
      dl2_negex[0] <= i_negex;
      dl2_par[0]   <= i_par;
      dl2_pmiss[0] <= i_pmiss;
      for (int k = 1; k < DIV_LAT; k++) begin
        dl2_negen[k] <= dl2_negen[k-1];
        dl2_negex[k] <= dl2_negex[k-1];
        dl2_par[k]   <= dl2_par[k-1];
        dl2_pmiss[k] <= dl2_pmiss[k-1];
      end
    end
  end

  // Stage J: signed slab bounds put in order
  logic signed [47:0] j_lo [3];
  logic signed [47:0] j_hi [3];
  logic [2:0]         j_par, j_pmiss;

  always_ff @(posedge clk) begin
    logic signed [47:0] en;
    logic signed [47:0] ex;
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        en = dl2_negen[DIV_LAT-1][j] ? -48'({1'b0, en_mag[j]}) : 48'({1'b0, en_mag[j]});
        ex = dl2_negex[DIV_LAT-1][j] ? -48'({1'b0, ex_mag[j]}) : 48'({1'b0, ex_mag[j]});
        j_lo[j] <= (en > ex) ? ex : en;
        j_hi[j] <= (en > ex) ? en : ex;
      end
      j_par   <= dl2_par[DIV_LAT-1];
      j_pmiss <= dl2_pmiss[DIV_LAT-1];
    end
  end

  // Stage K: interval merge into the output register
  logic signed [47:0] tmin, tmax;
  logic               hit;
  logic               o_hit;
  logic [MAG_W-1:0]   o_dist;

  always_comb begin
    tmin = '0;
    tmax = 48'({1'b0, SAT_MAG});
    for (int j = 0; j < 3; j++) begin
      if (!j_par[j]) begin
        if (j_lo[j] > tmin) tmin = j_lo[j];
        if (j_hi[j] < tmax) tmax = j_hi[j];
      end
    end
    hit = !(|(j_par & j_pmiss)) && (tmin <= tmax);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_hit  <= hit;
      o_dist <= hit ? tmin[MAG_W-1:0] : '0;
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = {o_dist, o_hit};

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the ray versus oriented box slab test pipeline.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import robb_pkg::*;

  localparam longint LIM = (64'd1 << 47) - 1;
  localparam int PIPE_LAT = 106;

  typedef struct packed {
    logic [47:0] tz, ty, tx, m22, m21, m20, m12, m11, m10, m02, m01, m00;
  } box_t;

  typedef struct packed {
    logic [46:0] entry_dist;
    logic        hit;
  } ray_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_ORG_X;
  logic [47:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [575:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  ray_oriented_box_slab_test DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the ray registers
  logic signed [47:0] ray_reg [6];
  box_t     box_queue [$];
  ray_hit_t hit_queue [$];
  int errors = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;

  // ---------------- fixed-point helpers ----------------
  function automatic longint clamp47(input logic signed [127:0] v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return longint'(v);
  endfunction

  // product cut toward zero to FRAC_BITS, saturated
  function automatic longint qmul(input longint a, input longint b);
    logic signed [127:0] p, m;
    p = 128'(a) * 128'(b);
    m = (p < 0) ? -p : p;
    m = m >>> FRAC_BITS;
    return clamp47((p < 0) ? -m : m);
  endfunction

  // (n << k) / d, toward zero, saturated; d positive
  function automatic longint qdiv(input logic signed [127:0] n, input int k,
                                  input logic [127:0] d);
    logic [127:0] nm, q;
    nm = (n < 0) ? -n : n;
    q = (nm << k) / d;
    if (q > LIM) q = LIM;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic ray_hit_t predict_hit(input box_t b);
    longint m [3][3], t [3], inv [3][3], lo [3], ld [3];
    logic [127:0] q2;
    logic signed [127:0] so, sd;
    longint tmin, tmax, en, ex, tmp, ad;
    ray_hit_t r;
    m[0][0] = $signed(b.m00); m[0][1] = $signed(b.m01); m[0][2] = $signed(b.m02);
    m[1][0] = $signed(b.m10); m[1][1] = $signed(b.m11); m[1][2] = $signed(b.m12);
    m[2][0] = $signed(b.m20); m[2][1] = $signed(b.m21); m[2][2] = $signed(b.m22);
    t[0] = $signed(b.tx); t[1] = $signed(b.ty); t[2] = $signed(b.tz);
    // shear-free inverse, tiny scale divides by 1
    for (int j = 0; j < 3; j++) begin
      q2 = 0;
      for (int i = 0; i < 3; i++) q2 += 128'(128'(m[j][i]) * 128'(m[j][i]));
      for (int i = 0; i < 3; i++)
        inv[i][j] = (q2 > 128'(SEPS_SQ)) ? qdiv(128'(m[j][i]), 2 * FRAC_BITS, q2)
                                         : m[j][i];
    end
    // ray into box space
    for (int j = 0; j < 3; j++) begin
      so = 0; sd = 0;
      for (int i = 0; i < 3; i++) begin
        so += 128'(qmul(longint'(ray_reg[i]) - t[i], inv[i][j]));
        sd += 128'(qmul(longint'(ray_reg[3 + i]), inv[i][j]));
      end
      lo[j] = clamp47(so);
      ld[j] = clamp47(sd);
    end
    // slab test
    tmin = 0; tmax = LIM; r = '0;
    for (int j = 0; j < 3; j++) begin
      ad = (ld[j] < 0) ? -ld[j] : ld[j];
      if (ad < DEPS_RAW) begin
        if (lo[j] < -(64'sd1 << FRAC_BITS) || lo[j] > (64'sd1 << FRAC_BITS)) return '0;
        continue;
      end
      en = qdiv(128'(-(64'sd1 << FRAC_BITS) - lo[j]) * ((ld[j] < 0) ? -1 : 1),
                FRAC_BITS, 128'(ad));
      ex = qdiv(128'((64'sd1 << FRAC_BITS) - lo[j]) * ((ld[j] < 0) ? -1 : 1),
                FRAC_BITS, 128'(ad));
      if (en > ex) begin tmp = en; en = ex; ex = tmp; end
      if (en > tmin) tmin = en;
      if (ex < tmax) tmax = ex;
      if (tmin > tmax) return '0;
    end
    r.hit = 1'b1;
    r.entry_dist = tmin[46:0];
    return r;
  endfunction

  // ---------------- stimulus values ----------------
  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [47:0] fx(input real v);
    return 48'(longint'(v * 16777216.0));
  endfunction

  // mostly modest values, some extremes, some raw noise
  function automatic logic [47:0] pick_val(input real span);
    int s;
    s = $urandom_range(0, 19);
    if (s == 0) return rand48();
    if (s == 1) return 48'h7FFF_FFFF_FFFF;
    if (s == 2) return 48'h8000_0000_0000;
    if (s == 3) return 48'h0;
    if (s == 4) return 48'($signed(16'($urandom())));
    return fx(span * ($itor($urandom_range(0, 2000000)) / 1000000.0 - 1.0));
  endfunction

  function automatic box_t rand_box();
    box_t b;
    b.m00 = pick_val(3.0); b.m01 = pick_val(3.0); b.m02 = pick_val(3.0);
    b.m10 = pick_val(3.0); b.m11 = pick_val(3.0); b.m12 = pick_val(3.0);
    b.m20 = pick_val(3.0); b.m21 = pick_val(3.0); b.m22 = pick_val(3.0);
    b.tx = pick_val(6.0); b.ty = pick_val(6.0); b.tz = pick_val(6.0);
    // axis-aligned scaled boxes hit often
    if ($urandom_range(0, 2) == 0) begin
      b.m01 = '0; b.m02 = '0; b.m10 = '0; b.m12 = '0; b.m20 = '0; b.m21 = '0;
    end
    return b;
  endfunction

  function automatic box_t diag_box(input real s, input real x, input real y,
                                    input real z);
    box_t b;
    b = '0;
    b.m00 = fx(s); b.m11 = fx(s); b.m22 = fx(s);
    b.tx = fx(x); b.ty = fx(y); b.tz = fx(z);
    return b;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        hit_queue = {hit_queue, predict_hit(box_t'(s_axis_tdata))};
      end
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        s_axis_tvalid <= 1'b0;
      end else if (box_queue.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= box_queue.pop_front();
        if ($urandom_range(0, 3) == 0)
          gap_cnt <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- monitor and result check ----------------
  always @(posedge clk) begin
    ray_hit_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = ray_hit_t'(m_axis_tdata);
        if (hit_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %h", m_axis_tdata);
        end else begin
          want = hit_queue.pop_front();
          if (got.hit !== want.hit || got.entry_dist !== want.entry_dist) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected hit=%0d dist=%h, got hit=%0d dist=%h",
                       want.hit, want.entry_dist, got.hit, got.entry_dist);
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 5) == 0)
          stall_cnt <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  // ---------------- configuration ----------------
  task automatic write_ray(input logic [47:0] v [6]);
    for (int i = 0; i < 6; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= v[i];
      ray_reg[i] = v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until the pipeline has drained
  task automatic drain();
    while (box_queue.size() > 0 || s_axis_tvalid || gap_cnt > 0 || hit_queue.size() > 0)
      @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic run_phase(input logic [47:0] v [6], input int n_items);
    write_ray(v);
    for (int k = 0; k < n_items; k++) box_queue = {box_queue, rand_box()};
    drain();
  endtask

  initial begin
    logic [47:0] v [6];
    for (int i = 0; i < 6; i++) ray_reg[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // degenerate ray at reset values: inside and outside the box
    box_queue = {box_queue, diag_box(1.0, 0.0, 0.0, 0.0)};
    box_queue = {box_queue, diag_box(1.0, 5.0, 0.0, 0.0)};
    drain();

    // directed: ray along +x from -10
    v = '{fx(-10.0), fx(0.25), fx(-0.5), fx(1.0), 0, 0};
    write_ray(v);
    box_queue = {box_queue, diag_box(1.0, 0.0, 0.0, 0.0)};
    box_queue = {box_queue, diag_box(2.0, 3.0, 1.0, 0.0)};
    box_queue = {box_queue, diag_box(1.0, -20.0, 0.0, 0.0)};
    box_queue = {box_queue, diag_box(1.0, 0.0, 5.0, 0.0)};
    box_queue = {box_queue, diag_box(0.0, 0.0, 0.0, 0.0)};
    box_queue = {box_queue, diag_box(0.0000005, 0.0, 0.0, 0.0)};
    box_queue = {box_queue, diag_box(0.00002, -10.0, 0.25, -0.5)};
    box_queue = {box_queue, diag_box(1000.0, 0.0, 0.0, 0.0)};
    box_queue = {box_queue, box_t'('1)};
    box_queue = {box_queue, box_t'({12{48'h7FFF_FFFF_FFFF}})};
    box_queue = {box_queue, box_t'({12{48'h8000_0000_0000}})};
    for (int k = 0; k < 6; k++) box_queue = {box_queue, rand_box()};
    // sender pauses until everything is back
    drain();

    // extreme ray registers
    v = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 0,
          48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1};
    run_phase(v, 60);
    v = '{'1, '1, '1, fx(0.00000005), 1, 0};
    run_phase(v, 60);

    // random rays, mostly through the origin region
    for (int p = 0; p < 13; p++) begin
      for (int i = 0; i < 3; i++) v[i] = pick_val(8.0);
      for (int i = 3; i < 6; i++) v[i] = pick_val(2.0);
      run_phase(v, 105);
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------- watchdog ----------------
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
src/robb_pkg.sv
src/robb_div.sv
src/ray_oriented_box_slab_test.sv
tb/sv/testbench.sv
